>>> sv/tspr_pkg.sv
package tspr_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NAME_BYTE = 2'd0;
  localparam logic [1:0] KIND_RECORD    = 2'd1;
  localparam logic [1:0] KIND_EXTRA_TAB = 2'd2;

  // Phases of the signed conversion.
  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_ACTIVE = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // Characters.
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;

  // Saturation limits.
  localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_TEN_LIMIT = 32'd429496729;
  localparam logic [63:0] MAG_CAP       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_TEN_LIMIT = 64'd922337203685477580;

  // Width of a result without its line index.
  localparam int RES_PAYLOAD_BITS = 2 + 8 + 32 + 64;

  typedef struct packed {
    logic [1:0]  field_number;
    logic [31:0] pos_acc;
    logic        pos_sat;
    logic        pos_stop;
    logic [63:0] len_mag;
    logic        len_neg;
    logic [1:0]  len_phase;
  } line_state_t;

  localparam line_state_t LINE_STATE_RESET = '0;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [31:0] mate_position;
    logic [63:0] template_length;
  } step_res_t;

endpackage

>>> sv/tspr_in_if.sv
interface tspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       block_end;

  modport source (output valid, output text_byte, output block_end, input ready);
  modport sink (input valid, input text_byte, input block_end, output ready);
endinterface

>>> sv/tspr_out_if.sv
interface tspr_out_if #(
  parameter int LINE_INDEX_BITS = 20
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [7:0]                 name_byte;
  logic [31:0]                mate_position;
  logic signed [63:0]         template_length;
  logic [LINE_INDEX_BITS-1:0] line_index;

  modport source (output valid, output kind, output name_byte, output mate_position,
                  output template_length, output line_index, input ready);
  modport sink (input valid, input kind, input name_byte, input mate_position,
                input template_length, input line_index, output ready);
endinterface

>>> sv/tspr_step.sv
module tspr_step
  import tspr_pkg::*;
(
  input  logic [7:0]  text_byte,
  input  line_state_t cur,
  output line_state_t nxt,
  output step_res_t   res
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] pos_times_ten;
  logic [63:0] mag_times_ten;
  logic [63:0] len_value;

  assign is_digit      = (text_byte >= CHR_0) && (text_byte <= CHR_9);
  assign digit         = 4'(text_byte - CHR_0);
  assign pos_times_ten = {cur.pos_acc[28:0], 3'b000} + {cur.pos_acc[30:0], 1'b0}
                         + {28'd0, digit};
  assign mag_times_ten = {cur.len_mag[60:0], 3'b000} + {cur.len_mag[62:0], 1'b0}
                         + {60'd0, digit};

  // Signed value of the current field as it stands.
  always_comb begin
    if (cur.len_neg) begin
      len_value = 64'd0 - cur.len_mag;
    end else if (cur.len_mag >= MAG_CAP) begin
      len_value = MAG_CAP - 64'd1;
    end else begin
      len_value = cur.len_mag;
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    if (text_byte == CHR_NL) begin
      res.valid           = 1'b1;
      res.kind            = KIND_RECORD;
      res.mate_position   = (cur.field_number >= 2'd2) ? cur.pos_acc : 32'd0;
      res.template_length = len_value;
      nxt                 = LINE_STATE_RESET;
    end else if (text_byte == CHR_TAB) begin
      if (cur.field_number >= 2'd2) begin
        res.valid        = 1'b1;
        res.kind         = KIND_EXTRA_TAB;
        nxt.field_number = 2'd2;
      end else begin
        nxt.field_number = cur.field_number + 2'd1;
      end
      nxt.len_mag   = '0;
      nxt.len_neg   = 1'b0;
      nxt.len_phase = PH_WAIT;
    end else begin
      if (cur.field_number == 2'd0) begin
        res.valid     = 1'b1;
        res.kind      = KIND_NAME_BYTE;
        res.name_byte = text_byte;
      end else if (cur.field_number == 2'd1 && !cur.pos_stop) begin
        if (is_digit) begin
          if (cur.pos_sat || cur.pos_acc > POS_TEN_LIMIT ||
              (cur.pos_acc == POS_TEN_LIMIT && digit > 4'd5)) begin
            nxt.pos_acc = POS_MAX;
            nxt.pos_sat = 1'b1;
          end else begin
            nxt.pos_acc = pos_times_ten;
          end
        end else begin
          nxt.pos_stop = 1'b1;
        end
      end

      // Signed conversion runs on every byte that is not a tab or newline, in every field.
      if (cur.len_phase < PH_STOP) begin
        if (is_digit) begin
          if (cur.len_mag > MAG_TEN_LIMIT || mag_times_ten > MAG_CAP) begin
            nxt.len_mag = MAG_CAP;
          end else begin
            nxt.len_mag = mag_times_ten;
          end
          nxt.len_phase = PH_ACTIVE;
        end else if (cur.len_phase == PH_WAIT) begin
          if (text_byte inside {CHR_SPACE, CHR_CR, CHR_VT, CHR_FF}) begin
            nxt.len_phase = PH_WAIT;
          end else if (text_byte == CHR_PLUS) begin
            nxt.len_phase = PH_ACTIVE;
          end else if (text_byte == CHR_MINUS) begin
            nxt.len_neg   = 1'b1;
            nxt.len_phase = PH_ACTIVE;
          end else begin
            nxt.len_phase = PH_STOP;
          end
        end else begin
          nxt.len_phase = PH_STOP;
        end
      end
    end
  end

endmodule

>>> sv/tspr_out_buf.sv
module tspr_out_buf #(
  parameter int WIDTH = 126
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             head_valid_r, head_valid_nxt;
  logic             tail_valid_r, tail_valid_nxt;
  logic [WIDTH-1:0] head_r, head_nxt;
  logic [WIDTH-1:0] tail_r, tail_nxt;
  logic             pop;

  assign pop       = head_valid_r && out_ready;
  assign space     = !tail_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  always_comb begin
    head_valid_nxt = head_valid_r;
    tail_valid_nxt = tail_valid_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    case ({push, pop})
      2'b10: begin
        if (!head_valid_r) begin
          head_nxt       = push_data;
          head_valid_nxt = 1'b1;
        end else begin
          tail_nxt       = push_data;
          tail_valid_nxt = 1'b1;
        end
      end
      2'b01: begin
        head_nxt       = tail_r;
        head_valid_nxt = tail_valid_r;
        tail_valid_nxt = 1'b0;
      end
      2'b11: begin
        if (tail_valid_r) begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end else begin
          head_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      tail_valid_r <= tail_valid_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> sv/tsv_pair_record_parser_core.sv
// A result enters the buffer at the transfer of the byte that causes it; the buffer head
// offers it. Throughput: one byte per cycle while the buffer has room; the per-line state
// (a times-ten accumulate on the 32-bit and 64-bit fields) is updated at each transfer.
// A two-entry result buffer lets bytes keep arriving while one result waits.
// Reset: synchronous, active low; clears the line state, the line counter and the buffer.
module tsv_pair_record_parser_core
  import tspr_pkg::*;
#(
  parameter int LINE_INDEX_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  tspr_in_if.sink    in_ch,
  tspr_out_if.source out_ch
);

  localparam int ITEM_BITS = RES_PAYLOAD_BITS + LINE_INDEX_BITS;

  // State of the line being parsed and the count of lines completed so far.
  line_state_t                line_r, line_nxt;
  logic [LINE_INDEX_BITS-1:0] line_cnt_r, line_cnt_nxt;

  line_state_t          step_nxt;
  step_res_t            step_res;
  logic                 accept;
  logic                 space;
  logic [ITEM_BITS-1:0] push_data;
  logic [ITEM_BITS-1:0] out_data;

  // A byte may be taken whenever the buffer has a free entry, even while the
  // head result is still waiting for its transfer.
  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  tspr_step u_step (
    .text_byte (in_ch.text_byte),
    .cur       (line_r),
    .nxt       (step_nxt),
    .res       (step_res)
  );

  // The last byte of a block is handled as usual, then everything returns to
  // its reset value so that the next block starts on a fresh line.
  always_comb begin
    line_nxt     = line_r;
    line_cnt_nxt = line_cnt_r;
    if (accept) begin
      if (in_ch.block_end) begin
        line_nxt     = LINE_STATE_RESET;
        line_cnt_nxt = '0;
      end else begin
        line_nxt = step_nxt;
        if (in_ch.text_byte == CHR_NL) begin
          line_cnt_nxt = line_cnt_r + LINE_INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= LINE_STATE_RESET;
      line_cnt_r <= '0;
    end else begin
      line_r     <= line_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // Every result carries the index of the line it belongs to.
  assign push_data = {step_res.kind, step_res.name_byte, step_res.mate_position,
                      step_res.template_length, line_cnt_r};

  tspr_out_buf #(
    .WIDTH (ITEM_BITS)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && step_res.valid),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.kind            = out_data[ITEM_BITS-1 -: 2];
  assign out_ch.name_byte       = out_data[ITEM_BITS-3 -: 8];
  assign out_ch.mate_position   = out_data[ITEM_BITS-11 -: 32];
  assign out_ch.template_length = out_data[LINE_INDEX_BITS +: 64];
  assign out_ch.line_index      = out_data[LINE_INDEX_BITS-1:0];

endmodule

>>> sv/tspr_checker.sv
module tspr_checker
  import tspr_pkg::*;
#(
  parameter int LINE_INDEX_BITS = 20
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 kind,
  input logic [7:0]                 name_byte,
  input logic [31:0]                mate_position,
  input logic [63:0]                template_length,
  input logic [LINE_INDEX_BITS-1:0] line_index
);

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (kind == KIND_NAME_BYTE || kind == KIND_RECORD ||
                   kind == KIND_EXTRA_TAB))
    else $error("unknown result kind");

  a_name_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_NAME_BYTE |-> mate_position == 32'd0 &&
                                           template_length == 64'd0)
    else $error("name byte carries numeric fields");

  a_other_no_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_NAME_BYTE |-> name_byte == 8'd0)
    else $error("non-name result carries a name byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(line_index) &&
                                $stable(template_length))
    else $error("stalled result changed");

endmodule

bind tsv_pair_record_parser_core tspr_checker #(
  .LINE_INDEX_BITS (LINE_INDEX_BITS)
) u_tspr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .kind            (out_ch.kind),
  .name_byte       (out_ch.name_byte),
  .mate_position   (out_ch.mate_position),
  .template_length (out_ch.template_length),
  .line_index      (out_ch.line_index)
);

>>> tb/sv/tb_tsv_pair_record_parser_core.sv
module tb_tsv_pair_record_parser_core;
  import tspr_pkg::*;

  // Width of the line index; the block is built with the same value.
  localparam int LIB = 20;
  // Least number of bytes sent by the random part of the run.
  localparam int RAND_BYTES = 1140;
  // Roughly one byte in this many closes a block during the random part.
  localparam int BLOCK_ODDS = 80;

  // How the result receiver paces its ready signal.
  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_HEAVY
  } sink_mode_e;

  // One result as the block should present it.
  typedef struct packed {
    logic [1:0]     kind;
    logic [7:0]     name_byte;
    logic [31:0]    mate_position;
    logic [63:0]    template_length;
    logic [LIB-1:0] line_index;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tspr_in_if in_ch();
  tspr_out_if #(.LINE_INDEX_BITS(LIB)) out_ch();

  tsv_pair_record_parser_core #(
    .LINE_INDEX_BITS(LIB)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser state as the testbench tracks it: the line being parsed and the line count.
  logic [1:0]     cur_field;
  logic [31:0]    mate_acc;
  logic           mate_sat;
  logic           mate_done;
  logic [63:0]    tlen_mag;
  logic           tlen_neg;
  logic [1:0]     tlen_phase;
  logic [LIB-1:0] line_count;

  // Results still owed by the block, oldest first.
  parse_result_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned names_seen = 0;
  int unsigned records_seen = 0;
  int unsigned extra_tabs_seen = 0;
  int unsigned blocks_closed = 0;
  int unsigned bytes_sent = 0;

  // Knobs shared between the test tasks, the sender and the receiver.
  sink_mode_e  sink_mode = SINK_ALWAYS;
  int unsigned hold_request = 0;
  bit          sender_gaps = 1'b1;
  int unsigned burst_left = 0;

  function automatic bit is_digit(logic [7:0] b);
    return (b >= CHR_0) && (b <= CHR_9);
  endfunction

  // The signed conversion restarts at every tab and at the start of each line.
  function void clear_tlen();
    tlen_mag   = '0;
    tlen_neg   = 1'b0;
    tlen_phase = PH_WAIT;
  endfunction

  function void clear_line_state();
    cur_field = '0;
    mate_acc  = '0;
    mate_sat  = 1'b0;
    mate_done = 1'b0;
    clear_tlen();
  endfunction

  // Advances the tracked state by one accepted byte and queues the result it
  // causes, if any. A byte that closes a block is handled first, and only then
  // does all state return to its value after reset.
  function void parse_byte(logic [7:0] b, bit last);
    parse_result_t r;
    bit            emit;
    logic [63:0]   d;
    r = '0;
    r.line_index = line_count;
    emit = 1'b0;
    d = {56'd0, b - CHR_0};
    if (b == CHR_NL) begin
      // A newline closes the record. The second field only counts once two
      // tabs have been seen; the signed value comes from whichever field is
      // current, so a line without tabs converts its name.
      r.kind = KIND_RECORD;
      r.mate_position = (cur_field >= 2'd2) ? mate_acc : '0;
      if (tlen_neg) begin
        r.template_length = -tlen_mag;
      end else if (tlen_mag >= MAG_CAP) begin
        r.template_length = MAG_CAP - 64'd1;
      end else begin
        r.template_length = tlen_mag;
      end
      emit = 1'b1;
      clear_line_state();
      line_count = line_count + LIB'(1);
    end else if (b == CHR_TAB) begin
      // A tab inside the third field is reported and the field starts over.
      if (cur_field >= 2'd2) begin
        r.kind = KIND_EXTRA_TAB;
        emit = 1'b1;
        cur_field = 2'd2;
      end else begin
        cur_field = cur_field + 2'd1;
      end
      clear_tlen();
    end else begin
      if (cur_field == 2'd0) begin
        r.kind = KIND_NAME_BYTE;
        r.name_byte = b;
        emit = 1'b1;
      end else if (cur_field == 2'd1 && !mate_done) begin
        // Digits only: a sign or a space ends the unsigned field at once.
        if (is_digit(b)) begin
          if (mate_sat || mate_acc > POS_TEN_LIMIT ||
              (mate_acc == POS_TEN_LIMIT && d > 64'd5)) begin
            mate_acc = POS_MAX;
            mate_sat = 1'b1;
          end else begin
            mate_acc = mate_acc * 32'd10 + d[31:0];
          end
        end else begin
          mate_done = 1'b1;
        end
      end
      // The signed conversion runs on every field, as the current one may
      // turn out to be the field that the newline converts.
      if (tlen_phase < PH_STOP) begin
        if (is_digit(b)) begin
          if (tlen_mag > MAG_TEN_LIMIT) begin
            tlen_mag = MAG_CAP;
          end else begin
            tlen_mag = tlen_mag * 64'd10 + d;
            if (tlen_mag > MAG_CAP) tlen_mag = MAG_CAP;
          end
          tlen_phase = PH_ACTIVE;
        end else if (tlen_phase == PH_WAIT) begin
          if (b == CHR_PLUS) begin
            tlen_phase = PH_ACTIVE;
          end else if (b == CHR_MINUS) begin
            tlen_neg = 1'b1;
            tlen_phase = PH_ACTIVE;
          end else if (!(b == CHR_SPACE || b == CHR_CR || b == CHR_VT || b == CHR_FF)) begin
            tlen_phase = PH_STOP;
          end
        end else begin
          tlen_phase = PH_STOP;
        end
      end
    end
    if (emit) pending_results.push_back(r);
    if (last) begin
      clear_line_state();
      line_count = '0;
      blocks_closed++;
    end
  endfunction

  // Offers one byte and returns at the edge where its transfer takes place.
  // The sender works in bursts; between bursts it may drop valid for a while.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (sender_gaps) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.block_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  function automatic bit block_roll();
    return $urandom_range(0, BLOCK_ODDS - 1) == 0;
  endfunction

  // Sends a string byte by byte; with rolled set, any byte may close a block.
  task automatic send_text(input string s, input bit rolled);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], rolled ? block_roll() : 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CHR_SPACE;
      1: return CHR_CR;
      2: return CHR_VT;
      default: return CHR_FF;
    endcase
  endfunction

  // Numbers on and around the saturation points of the two decimal fields.
  function automatic string edge_number(bit wide, int unsigned k);
    if (wide) begin
      case (k)
        0: return "9223372036854775807";
        1: return "9223372036854775808";
        2: return "9223372036854775809";
        3: return "9223372036854775810";
        default: return "18446744073709551616";
      endcase
    end else begin
      case (k)
        0: return "4294967295";
        1: return "4294967296";
        2: return "4294967294";
        3: return "4294967299";
        default: return "99999999999";
      endcase
    end
  endfunction

  // A decimal field: short numbers, long digit runs, values at the limits
  // (sometimes behind leading zeros) or nothing at all.
  task automatic send_decimal(input bit wide);
    int unsigned mode;
    int unsigned n;
    int unsigned i;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      n = $urandom_range(1, 3);
    end else if (mode < 6) begin
      n = $urandom_range(1, 22);
    end else begin
      n = 0;
    end
    for (i = 0; i < n; i++) send_byte(CHR_0 + 8'($urandom_range(0, 9)), block_roll());
    if (mode >= 6 && mode < 9) begin
      if (mode == 8) begin
        repeat ($urandom_range(1, 3)) send_byte(CHR_0, block_roll());
      end
      send_text(edge_number(wide, $urandom_range(0, 4)), 1'b1);
    end
  endtask

  // Every transfer on the result side is matched against the oldest
  // expectation. Outputs are read at the edge itself, so the values seen are
  // those of the cycle in which the transfer happened.
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      case (out_ch.kind)
        KIND_NAME_BYTE: names_seen++;
        KIND_RECORD:    records_seen++;
        KIND_EXTRA_TAB: extra_tabs_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, line_index %0d", out_ch.kind, out_ch.line_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          mismatches++;
        end
        if (out_ch.name_byte !== want.name_byte) begin
          $error("name_byte: expected %0d, got %0d", want.name_byte, out_ch.name_byte);
          mismatches++;
        end
        if (out_ch.mate_position !== want.mate_position) begin
          $error("mate_position: expected %0d, got %0d",
                 want.mate_position, out_ch.mate_position);
          mismatches++;
        end
        if (out_ch.template_length !== want.template_length) begin
          $error("template_length: expected %0d, got %0d",
                 $signed(want.template_length), out_ch.template_length);
          mismatches++;
        end
        if (out_ch.line_index !== want.line_index) begin
          $error("line_index: expected %0d, got %0d", want.line_index, out_ch.line_index);
          mismatches++;
        end
      end
    end
  end

  // The receiver follows its own pacing. A hold-off request is counted out
  // here, cycle by cycle, while the sender carries on regardless.
  initial begin : result_sink
    int unsigned cyc;
    int unsigned hold_len;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_request != 0) begin
        hold_len = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      case (sink_mode)
        SINK_ALWAYS:  out_ch.ready <= 1'b1;
        SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: out_ch.ready <= ((cyc % 7) < 4);
        default:      out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Name bytes at both ends of the byte range, then an ordinary record with
  // a space ahead of a negative length.
  task automatic test_field_extremes();
    sink_mode = SINK_RANDOM;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\t7\t -3\n", 1'b0);
  endtask

  // Lines that are short of fields, carry an extra tab, put a sign into the
  // unsigned field, or give blanks and a lone sign to the signed field.
  task automatic test_short_lines();
    sink_mode = SINK_PATTERN;
    send_text("5\n", 1'b0);
    send_text("\tx\t1\t+2\n", 1'b0);
    send_text("\t-4\t7\n", 1'b0);
    send_text("\t9\t", 1'b0);
    send_byte(CHR_CR, 1'b0);
    send_byte(CHR_VT, 1'b0);
    send_byte(CHR_FF, 1'b0);
    send_byte(CHR_MINUS, 1'b0);
    send_byte(CHR_NL, 1'b0);
  endtask

  // Block ends: one in the middle of a line, which then yields no record,
  // and one on a newline. The line index starts again from zero after each.
  task automatic test_block_end();
    sink_mode = SINK_HEAVY;
    send_text("ab\t1", 1'b0);
    send_byte(CHR_0 + 8'd2, 1'b1);
    send_text("c\t3\t4\n", 1'b0);
    send_text("d\t5\t6", 1'b0);
    send_byte(CHR_NL, 1'b1);
    send_text("e\t\t\n", 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender streams name
  // bytes without a gap, so the result buffer fills and input stalls.
  task automatic test_backpressure();
    logic [7:0] b;
    sink_mode = SINK_ALWAYS;
    sender_gaps = 1'b0;
    hold_request = 160;
    repeat (40) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHR_TAB || b == CHR_NL) b = CHR_PLUS;
      send_byte(b, 1'b0);
    end
    send_text("\t123\t-45\n", 1'b0);
    sender_gaps = 1'b1;
  endtask

  // Mostly well-formed lines with random content, the rest noise rich in
  // separators, digits, signs and blanks. Pacing on both sides changes now
  // and then, including stretches without any idling.
  task automatic test_random_lines();
    int unsigned first;
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    first = bytes_sent;
    sender_gaps = 1'b1;
    while (bytes_sent - first < RAND_BYTES) begin
      if ($urandom_range(0, 39) == 0) sink_mode = sink_mode_e'($urandom_range(0, 3));
      if ($urandom_range(0, 39) == 0) sender_gaps = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHR_TAB || b == CHR_NL) b = CHR_PLUS;
          send_byte(b, block_roll());
        end
        if ($urandom_range(0, 9) != 0) begin
          send_byte(CHR_TAB, block_roll());
          send_decimal(1'b0);
          if ($urandom_range(0, 9) == 0) send_byte(CHR_MINUS, block_roll());
          if ($urandom_range(0, 7) != 0) begin
            send_byte(CHR_TAB, block_roll());
            if ($urandom_range(0, 3) == 0) begin
              repeat ($urandom_range(1, 3)) send_byte(pick_blank(), block_roll());
            end
            k = $urandom_range(0, 4);
            if (k == 0) begin
              send_byte(CHR_PLUS, block_roll());
            end else if (k <= 2) begin
              send_byte(CHR_MINUS, block_roll());
            end
            send_decimal(1'b1);
            if ($urandom_range(0, 9) == 0) begin
              send_byte(CHR_TAB, block_roll());
              send_decimal(1'b1);
            end
            if ($urandom_range(0, 9) == 0) begin
              b = 8'($urandom_range(0, 255));
              if (b == CHR_NL) b = CHR_SPACE;
              send_byte(b, block_roll());
            end
          end
        end
        // Now and then the line is left open and runs into the next one.
        if ($urandom_range(0, 19) != 0) send_byte(CHR_NL, block_roll());
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: b = CHR_TAB;
            1: b = CHR_NL;
            2: b = CHR_0 + 8'($urandom_range(0, 9));
            3: b = $urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS;
            4: b = pick_blank();
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b, block_roll());
        end
      end
    end
  endtask

  initial begin : regression
    int i;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.block_end <= 1'b0;
    clear_line_state();
    line_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_short_lines();
    test_block_end();
    test_backpressure();
    test_random_lines();

    // The last transfer has just happened; stop offering and let the
    // receiver take everything that is still owed.
    in_ch.valid <= 1'b0;
    sink_mode = SINK_ALWAYS;
    for (i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Sent %0d bytes over %0d closed blocks, with one long receiver hold-off.",
             bytes_sent, blocks_closed);
    $display("Compared %0d name bytes, %0d records and %0d extra-tab reports; %0d mismatches.",
             names_seen, records_seen, extra_tabs_seen, mismatches);
    if (mismatches == 0) begin
      $display("tsv_pair_record_parser_core regression: pass");
    end else begin
      $display("tsv_pair_record_parser_core regression: fail");
    end
    $finish;
  end

  // Guards against a hung handshake on either side.
  initial begin : watchdog
    #400000;
    $display("tsv_pair_record_parser_core regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/tspr_pkg.sv
sv/tspr_in_if.sv
sv/tspr_out_if.sv
sv/tspr_step.sv
sv/tspr_out_buf.sv
sv/tsv_pair_record_parser_core.sv
sv/tspr_checker.sv
tb/sv/tb_tsv_pair_record_parser_core.sv
